>>> rtl/fpa_pkg.sv
// fpa_pkg: shared types and character codes for the four-part address parser
// no dependencies; imported by the interfaces and all rtl modules

package fpa_pkg;

  // character codes the parser reacts to
  localparam logic [7:0] CH_TERM     = 8'h00;
  localparam logic [7:0] CH_ZONE_SEP = 8'h3A;  // ':'
  localparam logic [7:0] CH_NET_SEP  = 8'h2F;  // '/'
  localparam logic [7:0] CH_NODE_SEP = 8'h2E;  // '.'
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;  // '0'
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'

  localparam int unsigned PART_W = 16;

  typedef logic [PART_W-1:0] part_t;

  // one parsed address, as delivered on the result channel
  typedef struct packed {
    logic  valid_res;
    part_t zone;
    part_t net;
    part_t node;
    part_t point;
  } addr_res_t;

  // character class of one input beat
  typedef enum logic [2:0] {
    CLS_TERM,
    CLS_ZONE,
    CLS_NET,
    CLS_NODE,
    CLS_DIGIT,
    CLS_OTHER
  } ch_class_t;

  // hand-off from the parser to the result register
  typedef struct packed {
    logic      load;
    addr_res_t res;
  } res_push_t;

endpackage

>>> rtl/fpa_ifs.sv
// fpa_ifs: valid/ready channel interfaces for characters in and addresses out
// depends on fpa_pkg

interface fpa_in_if
  import fpa_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface fpa_out_if
  import fpa_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  valid_res;
  part_t zone;
  part_t net;
  part_t node;
  part_t point;

  modport source (output valid, output valid_res, output zone, output net,
                  output node, output point, input ready);
  modport sink   (input valid, input valid_res, input zone, input net,
                  input node, input point, output ready);
endinterface

>>> rtl/fpa_parse.sv
// fpa_parse: per-character parser state and end-of-string result build
// depends on fpa_pkg

module fpa_parse
  import fpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  output res_push_t  push
);

  part_t accum_r, accum_nxt;
  part_t zone_r, zone_nxt;
  part_t net_r, net_nxt;
  part_t node_r, node_nxt;
  logic  seen_zone_r, seen_zone_nxt;
  logic  seen_net_r, seen_net_nxt;
  logic  seen_node_r, seen_node_nxt;
  logic  bad_r, bad_nxt;

  ch_class_t cls;
  part_t     accum_x10;
  addr_res_t res;

  // classify the incoming character
  always_comb begin
    if (ch == CH_TERM) begin
      cls = CLS_TERM;
    end else if (ch == CH_ZONE_SEP) begin
      cls = CLS_ZONE;
    end else if (ch == CH_NET_SEP) begin
      cls = CLS_NET;
    end else if (ch == CH_NODE_SEP) begin
      cls = CLS_NODE;
    end else if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // times ten as shift-add, wrapping at 16 bits
  assign accum_x10 = {accum_r[PART_W-4:0], 3'b000} + {accum_r[PART_W-2:0], 1'b0};

  // next parser state
  always_comb begin
    accum_nxt     = accum_r;
    zone_nxt      = zone_r;
    net_nxt       = net_r;
    node_nxt      = node_r;
    seen_zone_nxt = seen_zone_r;
    seen_net_nxt  = seen_net_r;
    seen_node_nxt = seen_node_r;
    bad_nxt       = bad_r;
    if (take) begin
      if (cls == CLS_TERM) begin
        accum_nxt     = '0;
        zone_nxt      = '0;
        net_nxt       = '0;
        node_nxt      = '0;
        seen_zone_nxt = 1'b0;
        seen_net_nxt  = 1'b0;
        seen_node_nxt = 1'b0;
        bad_nxt       = 1'b0;
      end else if (!bad_r) begin
        case (cls)
          CLS_ZONE: begin
            if (seen_zone_r || seen_net_r || seen_node_r) begin
              bad_nxt = 1'b1;
            end else begin
              zone_nxt      = accum_r;
              seen_zone_nxt = 1'b1;
              accum_nxt     = '0;
            end
          end
          CLS_NET: begin
            if (seen_net_r || seen_node_r) begin
              bad_nxt = 1'b1;
            end else begin
              net_nxt      = accum_r;
              seen_net_nxt = 1'b1;
              accum_nxt    = '0;
            end
          end
          CLS_NODE: begin
            if (seen_node_r) begin
              bad_nxt = 1'b1;
            end else begin
              node_nxt      = accum_r;
              seen_node_nxt = 1'b1;
              accum_nxt     = '0;
            end
          end
          CLS_DIGIT: begin
            accum_nxt = accum_x10 + {{(PART_W-4){1'b0}}, ch[3:0]};
          end
          default: begin
            bad_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      zone_r      <= '0;
      net_r       <= '0;
      node_r      <= '0;
      seen_zone_r <= 1'b0;
      seen_net_r  <= 1'b0;
      seen_node_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      zone_r      <= zone_nxt;
      net_r       <= net_nxt;
      node_r      <= node_nxt;
      seen_zone_r <= seen_zone_nxt;
      seen_net_r  <= seen_net_nxt;
      seen_node_r <= seen_node_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // result for a terminator: last value lands in net, point or node
  always_comb begin
    res = '0;
    if (!bad_r) begin
      res.valid_res = 1'b1;
      res.zone      = zone_r;
      res.net       = net_r;
      res.node      = node_r;
      if (seen_zone_r && !seen_net_r) begin
        res.net = accum_r;
      end else if (seen_node_r) begin
        res.point = accum_r;
      end else begin
        res.node = accum_r;
      end
    end
  end

  assign push.load = take && (cls == CLS_TERM);
  assign push.res  = res;

endmodule

>>> rtl/fpa_out_reg.sv
// fpa_out_reg: result register between the parser and the result channel
// depends on fpa_pkg and fpa_out_if

module fpa_out_reg
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  output logic      space,
  fpa_out_if.source out_res
);

  logic      full_r, full_nxt;
  addr_res_t data_r;

  // register can take a beat when empty or draining this cycle
  assign space = !full_r || out_res.ready;

  always_comb begin
    full_nxt = full_r;
    if (push.load) begin
      full_nxt = 1'b1;
    end else if (out_res.ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (push.load) begin
      data_r <= push.res;
    end
  end

  assign out_res.valid     = full_r;
  assign out_res.valid_res = data_r.valid_res;
  assign out_res.zone      = data_r.zone;
  assign out_res.net       = data_r.net;
  assign out_res.node      = data_r.node;
  assign out_res.point     = data_r.point;

endmodule

>>> rtl/four_part_address_parser.sv
// four_part_address_parser: parses zone:net/node.point from a character stream
// depends on fpa_pkg, fpa_ifs, fpa_parse, fpa_out_reg
//
//   channel  | dir | payload                          | beat
//   in_ch    | in  | ch[7:0]                          | one character
//   out_res  | out | valid_res, zone, net, node, point | one parsed address
//
// one character per cycle while in_ch is ready; the parser state updates at the accepting edge
// a terminator's address appears on out_res the cycle after it is accepted
// reset clears the parser state and empties the result register
// in_ch stalls only while a finished address waits and out_res is not ready

module four_part_address_parser
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_res
);

  logic      space;
  logic      take;
  res_push_t push;

  assign in_ch.ready = space;
  assign take        = in_ch.valid && space;

  // parser state
  fpa_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_ch.ch),
    .push  (push)
  );

  // result register
  fpa_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .space   (space),
    .out_res (out_res)
  );

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for four_part_address_parser
// depends on fpa_pkg, fpa_ifs and the parser rtl; predicts every address
// from the character stream and checks each result beat against it

module testbench;
  import fpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned CHAR_BUDGET = 1950;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // predicted parser state and the addresses still owed by the block
  class addr_scoreboard;
    part_t     acc;
    part_t     zone_r;
    part_t     net_r;
    part_t     node_r;
    bit        seen_zone;
    bit        seen_net;
    bit        seen_node;
    bit        bad;
    addr_res_t expected_q[$];
    int        errors;
    int        checked;
    int        invalid_seen;

    function new();
      clear_parse();
      errors       = 0;
      checked      = 0;
      invalid_seen = 0;
    endfunction

    function void clear_parse();
      acc       = '0;
      zone_r    = '0;
      net_r     = '0;
      node_r    = '0;
      seen_zone = 1'b0;
      seen_net  = 1'b0;
      seen_node = 1'b0;
      bad       = 1'b0;
    endfunction

    // advance the predicted parser by one accepted character
    function void note_char(logic [7:0] c);
      addr_res_t r;
      if (c == CH_TERM) begin
        r = '0;
        if (!bad) begin
          r.valid_res = 1'b1;
          r.zone      = zone_r;
          r.net       = net_r;
          r.node      = node_r;
          // trailing value lands according to the separators seen
          if (seen_zone && !seen_net) r.net = acc;
          else if (seen_node)         r.point = acc;
          else                        r.node = acc;
        end
        expected_q.push_back(r);
        clear_parse();
        return;
      end
      // characters after an error are dropped until the terminator
      if (bad) return;
      case (c)
        CH_ZONE_SEP: begin
          if (seen_zone || seen_net || seen_node) bad = 1'b1;
          else begin
            zone_r    = acc;
            seen_zone = 1'b1;
            acc       = '0;
          end
        end
        CH_NET_SEP: begin
          if (seen_net || seen_node) bad = 1'b1;
          else begin
            net_r    = acc;
            seen_net = 1'b1;
            acc      = '0;
          end
        end
        CH_NODE_SEP: begin
          if (seen_node) bad = 1'b1;
          else begin
            node_r    = acc;
            seen_node = 1'b1;
            acc       = '0;
          end
        end
        default: begin
          if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
            acc = part_t'(acc * RADIX + (c - CH_DIGIT_LO));
          else
            bad = 1'b1;
        end
      endcase
    endfunction

    // compare one result beat with the oldest owed address
    function void check_addr(addr_res_t got);
      addr_res_t want;
      if (expected_q.size() == 0) begin
        $error("address beat with nothing expected: valid_res=%0d zone=%0d net=%0d",
               got.valid_res, got.zone, got.net);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (!want.valid_res) invalid_seen++;
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res mismatch: expected %0d, actual %0d", want.valid_res, got.valid_res);
        errors++;
      end
      if (got.zone !== want.zone) begin
        $error("zone mismatch: expected %0d, actual %0d", want.zone, got.zone);
        errors++;
      end
      if (got.net !== want.net) begin
        $error("net mismatch: expected %0d, actual %0d", want.net, got.net);
        errors++;
      end
      if (got.node !== want.node) begin
        $error("node mismatch: expected %0d, actual %0d", want.node, got.node);
        errors++;
      end
      if (got.point !== want.point) begin
        $error("point mismatch: expected %0d, actual %0d", want.point, got.point);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fpa_in_if  in_if ();
  fpa_out_if out_if ();

  four_part_address_parser u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_res (out_if)
  );

  addr_scoreboard sb = new();

  logic [7:0]  str_q[$];
  int unsigned chars_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one character beat, with an optional idle gap first
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk); while (!in_if.ready);
    sb.note_char(c);
    chars_sent++;
  endtask

  // send the queued characters followed by the terminator
  task automatic send_string();
    foreach (str_q[i]) send_char(str_q[i]);
    send_char(CH_TERM);
    str_q.delete();
  endtask

  function automatic void push_text(string s);
    foreach (s[i]) str_q.push_back(s[i]);
  endfunction

  // one numeric part: empty, extreme, ordinary, or long enough to wrap
  function automatic void push_number();
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(0, 9);
    if (pick == 0) return;
    if (pick >= 8) begin
      repeat ($urandom_range(6, 9)) str_q.push_back(8'(CH_DIGIT_LO + $urandom_range(0, 9)));
      return;
    end
    if (pick == 1)      v = 0;
    else if (pick == 2) v = 65535;
    else if (pick <= 5) v = $urandom_range(0, 99);
    else                v = $urandom_range(0, 65535);
    push_text($sformatf("%0d", v));
  endfunction

  // well-formed [zone:][net/]node[.point] with random parts
  function automatic void push_address();
    logic [2:0] form;
    form = 3'($urandom);
    if (form[0]) begin
      push_number();
      str_q.push_back(CH_ZONE_SEP);
    end
    if (form[1]) begin
      push_number();
      str_q.push_back(CH_NET_SEP);
    end
    push_number();
    if (form[2]) begin
      str_q.push_back(CH_NODE_SEP);
      push_number();
    end
  endfunction

  // a stray separator or foreign byte dropped somewhere into the string
  function automatic logic [7:0] stray_char();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: return CH_ZONE_SEP;
      1: return CH_NET_SEP;
      2: return CH_NODE_SEP;
      default: begin
        do b = 8'($urandom_range(1, 255));
        while ((b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) || b == CH_ZONE_SEP ||
               b == CH_NET_SEP || b == CH_NODE_SEP);
        return b;
      end
    endcase
  endfunction

  // result side: random back-pressure with occasional long ready stretches
  initial begin
    int stall;
    out_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // check every address beat
  always @(posedge clk) begin
    addr_res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.valid_res = out_if.valid_res;
      got.zone      = out_if.zone;
      got.net       = out_if.net;
      got.node      = out_if.node;
      got.point     = out_if.point;
      sb.check_addr(got);
    end
  end

  // reset, directed strings, random strings, drain
  initial begin
    int unsigned kind;
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full four-part address
    push_text("1:2/3.4");
    send_string();
    // empty string
    send_string();
    // zone without net: trailing value is the net
    push_text("7:8");
    send_string();
    // empty net and node, point from nothing
    push_text("/.");
    send_string();
    // second colon is out of order
    push_text("::");
    send_string();
    // foreign byte, later digits ignored
    str_q.push_back(8'hFF);
    push_text("5");
    send_string();
    // digit overflow wraps at 16 bits
    push_text("70000");
    send_string();

    // random strings: mostly well-formed, some broken, some noise
    while (chars_sent < CHAR_BUDGET) begin
      calm = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        push_address();
      end else if (kind < 85) begin
        push_address();
        str_q.insert($urandom_range(0, str_q.size()), stray_char());
      end else begin
        repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(1, 255)));
      end
      send_string();
    end
    in_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d characters; checked %0d addresses, %0d of them flagged invalid",
             chars_sent, sb.checked, sb.invalid_seen);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> four_part_address_parser.f
rtl/fpa_pkg.sv
rtl/fpa_ifs.sv
rtl/fpa_parse.sv
rtl/fpa_out_reg.sv
rtl/four_part_address_parser.sv
tb/testbench.sv
